// ===== rtl/rpaf_pkg.sv =====
package rpaf_pkg;

    localparam int MAX_SOURCES    = 64;
    localparam int POS_FRAC_BITS  = 16;
    localparam int QUAT_FRAC_BITS = 14;

    localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
    localparam int POS_W  = 32;
    localparam int Q_W    = 16;
    localparam int ATTR_W = 32;
    localparam int DATA_W = 3 * POS_W + 4 * Q_W + ATTR_W;
    localparam int CMD_W  = 2;

    // Operand and accumulator widths for the shared multiply-accumulate
    localparam int B_W    = 37;
    localparam int PROD_W = Q_W + B_W;
    localparam int ACC_W  = 56;
    localparam int RND_W  = ACC_W - QUAT_FRAC_BITS;
    localparam int R_W    = 40;
    localparam int O_W    = 21;
    localparam int SUM_W  = R_W + 2;

    localparam int NSTEP  = 31;
    localparam int STEP_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_DEST   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CALC, ST_FIN, ST_OUT
    } t_state;

    typedef enum logic [1:0] { A_QX, A_QY, A_QZ, A_QW } t_asel;

    typedef enum logic [3:0] {
        B_VX, B_VY, B_VZ, B_TX, B_TY, B_TZ, B_BX, B_BY, B_BZ, B_BW
    } t_bsel;

    typedef enum logic [3:0] {
        D_TX, D_TY, D_TZ, D_RX, D_RY, D_RZ, D_OX, D_OY, D_OZ, D_OW
    } t_dst;

    typedef struct packed {
        t_asel a;
        t_bsel b;
        logic  sub;
        logic  first;
        logic  last;
        logic  dbl;
        t_dst  dst;
    } t_uop;

    typedef struct packed {
        logic              src_wr;
        logic              clear;
        logic              dest_load;
        logic              idx_clr;
        logic              idx_inc;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              fin;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic idx_last;
    } t_stat;

    function automatic t_uop mk(t_asel a, t_bsel b, logic sub, logic first,
                                logic last, logic dbl, t_dst dst);
        t_uop u;
        u.a = a; u.b = b; u.sub = sub; u.first = first;
        u.last = last; u.dbl = dbl; u.dst = dst;
        return u;
    endfunction

    // Micro-program: t = 2*cross(q,v), r = qw*t + cross(q,t), o = q * b
    function automatic t_uop uop(logic [STEP_W-1:0] s);
        t_uop u;
        case (s)
            5'd0:  u = mk(A_QY, B_VZ, 1'b0, 1'b1, 1'b0, 1'b1, D_TX);
            5'd1:  u = mk(A_QZ, B_VY, 1'b1, 1'b0, 1'b1, 1'b1, D_TX);
            5'd2:  u = mk(A_QZ, B_VX, 1'b0, 1'b1, 1'b0, 1'b1, D_TY);
            5'd3:  u = mk(A_QX, B_VZ, 1'b1, 1'b0, 1'b1, 1'b1, D_TY);
            5'd4:  u = mk(A_QX, B_VY, 1'b0, 1'b1, 1'b0, 1'b1, D_TZ);
            5'd5:  u = mk(A_QY, B_VX, 1'b1, 1'b0, 1'b1, 1'b1, D_TZ);
            5'd6:  u = mk(A_QW, B_TX, 1'b0, 1'b1, 1'b0, 1'b0, D_RX);
            5'd7:  u = mk(A_QY, B_TZ, 1'b0, 1'b0, 1'b0, 1'b0, D_RX);
            5'd8:  u = mk(A_QZ, B_TY, 1'b1, 1'b0, 1'b1, 1'b0, D_RX);
            5'd9:  u = mk(A_QW, B_TY, 1'b0, 1'b1, 1'b0, 1'b0, D_RY);
            5'd10: u = mk(A_QZ, B_TX, 1'b0, 1'b0, 1'b0, 1'b0, D_RY);
            5'd11: u = mk(A_QX, B_TZ, 1'b1, 1'b0, 1'b1, 1'b0, D_RY);
            5'd12: u = mk(A_QW, B_TZ, 1'b0, 1'b1, 1'b0, 1'b0, D_RZ);
            5'd13: u = mk(A_QX, B_TY, 1'b0, 1'b0, 1'b0, 1'b0, D_RZ);
            5'd14: u = mk(A_QY, B_TX, 1'b1, 1'b0, 1'b1, 1'b0, D_RZ);
            5'd15: u = mk(A_QX, B_BW, 1'b0, 1'b1, 1'b0, 1'b0, D_OX);
            5'd16: u = mk(A_QW, B_BX, 1'b0, 1'b0, 1'b0, 1'b0, D_OX);
            5'd17: u = mk(A_QY, B_BZ, 1'b0, 1'b0, 1'b0, 1'b0, D_OX);
            5'd18: u = mk(A_QZ, B_BY, 1'b1, 1'b0, 1'b1, 1'b0, D_OX);
            5'd19: u = mk(A_QY, B_BW, 1'b0, 1'b1, 1'b0, 1'b0, D_OY);
            5'd20: u = mk(A_QW, B_BY, 1'b0, 1'b0, 1'b0, 1'b0, D_OY);
            5'd21: u = mk(A_QZ, B_BX, 1'b0, 1'b0, 1'b0, 1'b0, D_OY);
            5'd22: u = mk(A_QX, B_BZ, 1'b1, 1'b0, 1'b1, 1'b0, D_OY);
            5'd23: u = mk(A_QZ, B_BW, 1'b0, 1'b1, 1'b0, 1'b0, D_OZ);
            5'd24: u = mk(A_QW, B_BZ, 1'b0, 1'b0, 1'b0, 1'b0, D_OZ);
            5'd25: u = mk(A_QX, B_BY, 1'b0, 1'b0, 1'b0, 1'b0, D_OZ);
            5'd26: u = mk(A_QY, B_BX, 1'b1, 1'b0, 1'b1, 1'b0, D_OZ);
            5'd27: u = mk(A_QW, B_BW, 1'b0, 1'b1, 1'b0, 1'b0, D_OW);
            5'd28: u = mk(A_QX, B_BX, 1'b1, 1'b0, 1'b0, 1'b0, D_OW);
            5'd29: u = mk(A_QY, B_BY, 1'b1, 1'b0, 1'b0, 1'b0, D_OW);
            5'd30: u = mk(A_QZ, B_BZ, 1'b1, 1'b0, 1'b1, 1'b0, D_OW);
            default: u = mk(A_QX, B_VX, 1'b0, 1'b0, 1'b0, 1'b0, D_TX);
        endcase
        return u;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (x > hi)      return hi[POS_W-1:0];
        else if (x < lo) return lo[POS_W-1:0];
        else             return x[POS_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] sat_q(logic signed [O_W-1:0] x);
        logic signed [O_W-1:0] hi;
        logic signed [O_W-1:0] lo;
        hi = O_W'((32'sd1 <<< (Q_W - 1)) - 32'sd1);
        lo = -hi - O_W'(1);
        if (x > hi)      return hi[Q_W-1:0];
        else if (x < lo) return lo[Q_W-1:0];
        else             return x[Q_W-1:0];
    endfunction

endpackage

// ===== rtl/rpaf_ram.sv =====
module rpaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rpaf_ctrl.sv =====
module rpaf_ctrl
    import rpaf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_cmd_code'(i_in_cmd))
                        CMD_APPEND: o_cmd.src_wr = !i_stat.full;
                        CMD_CLEAR:  o_cmd.clear  = 1'b1;
                        CMD_DEST: begin
                            o_cmd.dest_load = 1'b1;
                            o_cmd.idx_clr   = 1'b1;
                            if (!i_stat.cnt_zero) n_state = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_step  = '0;
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_step == STEP_W'(NSTEP)) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.issue = 1'b1;
                    n_step      = r_step + STEP_W'(1);
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.idx_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/rpaf_dp.sv =====
module rpaf_dp
    import rpaf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DATA_W-1:0] i_in_data,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic [DATA_W-1:0] o_out_data,
    output logic              o_out_last
);

    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] w_src;

    logic signed [POS_W-1:0] r_d [3];
    logic signed [Q_W-1:0]   r_q [4];
    logic signed [B_W-1:0]   r_t [3];
    logic signed [R_W-1:0]   r_r [3];
    logic signed [O_W-1:0]   r_o [4];

    logic signed [PROD_W-1:0] r_prod;
    t_uop                     r_pu;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DATA_W-1:0]        r_out;
    logic                     r_last;

    t_uop                     w_u;
    logic signed [Q_W-1:0]    w_a;
    logic signed [B_W-1:0]    w_b;
    logic signed [B_W-1:0]    w_v [3];
    logic signed [B_W-1:0]    w_bq [4];
    logic signed [ACC_W-1:0]  w_sum, w_pre;
    logic signed [RND_W-1:0]  w_rnd;
    logic signed [SUM_W-1:0]  w_pos [3];

    rpaf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SOURCES)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.src_wr),
        .i_waddr(r_cnt[IDX_W-1:0]),
        .i_wdata(i_in_data),
        .i_raddr(r_idx),
        .o_rdata(w_src)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
            r_pv  <= 1'b0;
        end else begin
            if (i_cmd.clear)       r_cnt <= '0;
            else if (i_cmd.src_wr) r_cnt <= r_cnt + CNT_W'(1);
            if (i_cmd.idx_clr)      r_idx <= '0;
            else if (i_cmd.idx_inc) r_idx <= r_idx + IDX_W'(1);
            r_pv <= i_cmd.issue;
        end
    end

    assign o_stat.full     = (r_cnt == CNT_W'(MAX_SOURCES));
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.idx_last = (CNT_W'(r_idx) == (r_cnt - CNT_W'(1)));

    // Source entry fields, sign-extended to the multiplier operand width
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = B_W'(signed'(w_src[i*POS_W +: POS_W]));
        end
        for (int i = 0; i < 4; i++) begin
            w_bq[i] = B_W'(signed'(w_src[3*POS_W + i*Q_W +: Q_W]));
        end
    end

    assign w_u = uop(i_cmd.step);

    always_comb begin
        case (w_u.a)
            A_QX:    w_a = r_q[0];
            A_QY:    w_a = r_q[1];
            A_QZ:    w_a = r_q[2];
            default: w_a = r_q[3];
        endcase
        case (w_u.b)
            B_VX:    w_b = w_v[0];
            B_VY:    w_b = w_v[1];
            B_VZ:    w_b = w_v[2];
            B_TX:    w_b = r_t[0];
            B_TY:    w_b = r_t[1];
            B_TZ:    w_b = r_t[2];
            B_BX:    w_b = w_bq[0];
            B_BY:    w_b = w_bq[1];
            B_BZ:    w_b = w_bq[2];
            default: w_b = w_bq[3];
        endcase
    end

    // Accumulate stage, then round half up on the last term of a group
    always_comb begin
        w_sum = r_pu.first ? '0 : r_acc;
        if (r_pu.sub) w_sum = w_sum - ACC_W'(r_prod);
        else          w_sum = w_sum + ACC_W'(r_prod);
        w_pre = r_pu.dbl ? (w_sum <<< 1) : w_sum;
        w_pre = w_pre + (ACC_W'(1) <<< (QUAT_FRAC_BITS - 1));
        w_rnd = RND_W'(w_pre >>> QUAT_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dest_load) begin
            for (int i = 0; i < 3; i++) r_d[i] <= i_in_data[i*POS_W +: POS_W];
            for (int i = 0; i < 4; i++) r_q[i] <= i_in_data[3*POS_W + i*Q_W +: Q_W];
        end
        if (i_cmd.issue) begin
            r_prod <= w_a * w_b;
            r_pu   <= w_u;
        end
        if (r_pv) begin
            r_acc <= w_sum;
            if (r_pu.last) begin
                case (r_pu.dst)
                    D_TX:    r_t[0] <= B_W'(w_rnd);
                    D_TY:    r_t[1] <= B_W'(w_rnd);
                    D_TZ:    r_t[2] <= B_W'(w_rnd);
                    D_RX:    r_r[0] <= R_W'(w_rnd);
                    D_RY:    r_r[1] <= R_W'(w_rnd);
                    D_RZ:    r_r[2] <= R_W'(w_rnd);
                    D_OX:    r_o[0] <= O_W'(w_rnd);
                    D_OY:    r_o[1] <= O_W'(w_rnd);
                    D_OZ:    r_o[2] <= O_W'(w_rnd);
                    default: r_o[3] <= O_W'(w_rnd);
                endcase
            end
        end
        if (i_cmd.fin) begin
            for (int i = 0; i < 3; i++) r_out[i*POS_W +: POS_W] <= sat_pos(w_pos[i]);
            for (int i = 0; i < 4; i++) r_out[3*POS_W + i*Q_W +: Q_W] <= sat_q(r_o[i]);
            r_out[3*POS_W + 4*Q_W +: ATTR_W] <= w_src[3*POS_W + 4*Q_W +: ATTR_W];
            r_last <= o_stat.idx_last;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pos[i] = SUM_W'(w_v[i]) + SUM_W'(r_r[i]) + SUM_W'(r_d[i]);
        end
    end

    assign o_out_data = r_out;
    assign o_out_last = r_last;

endmodule

// ===== rtl/repeat_points_at_frames_core.sv =====
// Point instancing core: places every stored source point at each destination.
//
// Input stream (i_s_*): tuser carries the command. Append stores a source point
// (position, quaternion, attribute) at the end of a 64-entry store; a full store
// drops the append. Clear empties the store. Destination starts a run: one result
// per stored source, in store order, with tlast on the final one. An empty store
// gives no results; an unused command is dropped.
// Output stream (o_m_*): placed position (source rotated by the destination
// quaternion plus destination position, saturated), combined quaternion
// (destination times source, saturated) and the source attribute.
// Timing: append and clear are done in the idle state. Each result passes through
// one store read, 31 multiply-accumulate steps on a single 16x37 multiplier, one
// drain step, one saturate step and one output step; the receiver can hold the
// output step with tready low. Input is not taken during a run: the next input
// item is taken the cycle after the last result is accepted.
// Reset: synchronous, active low; the store empties, no result pending.
// Stall: a result waits in the output register with tvalid high until taken.
module repeat_points_at_frames_core
    import rpaf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w, attribute
    input  logic [DATA_W-1:0] i_s_tdata,
    // cmd
    input  logic [CMD_W-1:0]  i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y, out_rot_z,
    // out_rot_w, out_attribute
    output logic [DATA_W-1:0] o_m_tdata,
    output logic              o_m_tlast
);

    t_cmd  w_cmd;
    t_stat w_stat;

    rpaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_cmd   (i_s_tuser),
        .o_in_ready (o_s_tready),
        .o_out_valid(o_m_tvalid),
        .i_out_ready(i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rpaf_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_s_tdata),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_out_data(o_m_tdata),
        .o_out_last(o_m_tlast)
    );

endmodule

// ===== rtl/rpaf_checker.sv =====
module rpaf_checker
    import rpaf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [DATA_W-1:0] o_m_tdata,
    input logic              o_m_tlast
);

    // Input is never taken while a result is offered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid)) else $error("ready while result pending");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid) else $error("result after reset");

    // Last result returns the block to taking input
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast |=> o_s_tready)
        else $error("not ready after last");

    // Within a run the next result needs a full compute pass
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> !o_m_tvalid && !o_s_tready)
        else $error("result too early");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind repeat_points_at_frames_core rpaf_checker u_rpaf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tlast (o_m_tlast)
);

// ===== verif/repeat_points_at_frames_core_test.sv =====
`timescale 1ns / 100ps

module repeat_points_at_frames_core_test;
    import rpaf_pkg::*;

    // One placed point as it leaves the block
    typedef struct {
        logic [POS_W-1:0] px, py, pz;
        logic [Q_W-1:0]   qx, qy, qz, qw;
        logic [ATTR_W-1:0] attr;
        logic             last;
    } t_placed;

    // One input point
    typedef struct {
        t_cmd_code        cmd;
        logic [POS_W-1:0] px, py, pz;
        logic [Q_W-1:0]   qx, qy, qz, qw;
        logic [ATTR_W-1:0] attr;
    } t_point;

    localparam int WATCHDOG_LIMIT = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    // pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w, attribute
    logic [DATA_W-1:0] i_s_tdata;
    // cmd
    logic [CMD_W-1:0]  i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    // out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y, out_rot_z,
    // out_rot_w, out_attribute
    logic [DATA_W-1:0] o_m_tdata;
    logic              o_m_tlast;

    repeat_points_at_frames_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Shadow copy of the source store
    t_point  source_store[MAX_SOURCES];
    int      source_count;
    t_placed placed_queue[$];
    int      mismatch_count = 0;
    int      watchdog;
    logic    timed_out;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Round half up at the quaternion fraction; arithmetic shift floors
    function automatic longint qround(longint x);
        return (x + (64'sd1 <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(longint x);
        if (x > 64'sd2147483647) return 32'h7fffffff;
        if (x < -64'sd2147483648) return 32'h80000000;
        return x[POS_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] clamp_quat(longint x);
        if (x > 64'sd32767) return 16'h7fff;
        if (x < -64'sd32768) return 16'h8000;
        return x[Q_W-1:0];
    endfunction

    // Place one stored source at a destination frame
    function automatic t_placed place_source(t_point d, t_point s, logic is_last);
        t_placed r;
        longint ax, ay, az, aw, dx, dy, dz, vx, vy, vz, bx, by, bz, bw;
        longint tx, ty, tz, rx, ry, rz;
        ax = longint'($signed(d.qx)); ay = longint'($signed(d.qy));
        az = longint'($signed(d.qz)); aw = longint'($signed(d.qw));
        dx = longint'($signed(d.px)); dy = longint'($signed(d.py));
        dz = longint'($signed(d.pz));
        vx = longint'($signed(s.px)); vy = longint'($signed(s.py));
        vz = longint'($signed(s.pz));
        bx = longint'($signed(s.qx)); by = longint'($signed(s.qy));
        bz = longint'($signed(s.qz)); bw = longint'($signed(s.qw));
        tx = qround(2 * (ay * vz - az * vy));
        ty = qround(2 * (az * vx - ax * vz));
        tz = qround(2 * (ax * vy - ay * vx));
        rx = qround(aw * tx + (ay * tz - az * ty));
        ry = qround(aw * ty + (az * tx - ax * tz));
        rz = qround(aw * tz + (ax * ty - ay * tx));
        r.px = clamp_pos(vx + rx + dx);
        r.py = clamp_pos(vy + ry + dy);
        r.pz = clamp_pos(vz + rz + dz);
        r.qx = clamp_quat(qround(ax * bw + bx * aw + (ay * bz - az * by)));
        r.qy = clamp_quat(qround(ay * bw + by * aw + (az * bx - ax * bz)));
        r.qz = clamp_quat(qround(az * bw + bz * aw + (ax * by - ay * bx)));
        r.qw = clamp_quat(qround(aw * bw - (ax * bx + ay * by + az * bz)));
        r.attr = s.attr;
        r.last = is_last;
        return r;
    endfunction

    // Update the shadow store and queue the placements a point causes
    function automatic void predict_point(t_point p);
        case (p.cmd)
            CMD_APPEND: begin
                if (source_count < MAX_SOURCES) begin
                    source_store[source_count] = p;
                    source_count++;
                end
            end
            CMD_CLEAR: source_count = 0;
            CMD_DEST: begin
                for (int i = 0; i < source_count; i++)
                    placed_queue.insert(placed_queue.size(),
                                        place_source(p, source_store[i],
                                                     i == source_count - 1));
            end
            default: ;
        endcase
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one point; hold valid until the block takes it
    task automatic send_point(t_point p);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= p.cmd;
        i_s_tdata  <= {p.attr, p.qw, p.qz, p.qy, p.qx, p.pz, p.py, p.px};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_point(p);
    endtask

    function automatic t_point rand_point(t_cmd_code c);
        t_point p;
        p.cmd = c;
        p.px = $urandom; p.py = $urandom; p.pz = $urandom; p.attr = $urandom;
        p.qx = Q_W'($urandom); p.qy = Q_W'($urandom);
        p.qz = Q_W'($urandom); p.qw = Q_W'($urandom);
        // Keep positions moderate most of the time so saturation stays rare
        if ($urandom_range(0, 3) != 0) begin
            p.px = {{12{p.px[19]}}, p.px[19:0]};
            p.py = {{12{p.py[19]}}, p.py[19:0]};
            p.pz = {{12{p.pz[19]}}, p.pz[19:0]};
        end
        return p;
    endfunction

    function automatic t_point fixed_point(t_cmd_code c, logic [POS_W-1:0] pv,
                                           logic [Q_W-1:0] qv, logic [Q_W-1:0] wv);
        t_point p;
        p.cmd = c;
        p.px = pv; p.py = pv; p.pz = pv;
        p.qx = qv; p.qy = qv; p.qz = qv; p.qw = wv;
        p.attr = ~pv;
        return p;
    endfunction

    // Drain: drop valid, wait until every placement has come back, then settle
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (placed_queue.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Extremes, identity, empty store, unused command, clear
    task automatic test_directed();
        send_point(fixed_point(CMD_DEST, 32'h0, 16'h0, 16'h4000));   // empty store
        send_point(fixed_point(CMD_APPEND, 32'h00010000, 16'h0, 16'h4000));
        send_point(fixed_point(CMD_APPEND, 32'h7fffffff, 16'h7fff, 16'h7fff));
        send_point(fixed_point(CMD_APPEND, 32'h80000000, 16'h8000, 16'h8000));
        send_point(fixed_point(CMD_APPEND, 32'hffffffff, 16'hffff, 16'h0));
        send_point(fixed_point(CMD_DEST, 32'h0, 16'h0, 16'h4000));
        send_point(fixed_point(CMD_DEST, 32'h7fffffff, 16'h7fff, 16'h7fff));
        send_point(fixed_point(CMD_DEST, 32'h80000000, 16'h8000, 16'h8000));
        send_point(fixed_point(CMD_NONE, 32'h12345678, 16'h1234, 16'h4321));
        send_point(fixed_point(CMD_DEST, 32'h55555555, 16'haaaa, 16'h5555));
        send_point(fixed_point(CMD_CLEAR, 32'hffffffff, 16'hffff, 16'hffff));
        send_point(fixed_point(CMD_DEST, 32'h0, 16'h4000, 16'h0));   // empty again
        send_point(fixed_point(CMD_APPEND, 32'hfffe0000, 16'h2d41, 16'h2d41));
        send_point(fixed_point(CMD_DEST, 32'h00030000, 16'hd2bf, 16'h2d41));
    endtask

    // Fill past capacity, check the dropped appends never show up
    task automatic test_full_store();
        send_point(rand_point(CMD_CLEAR));
        for (int i = 0; i < MAX_SOURCES + 3; i++) send_point(rand_point(CMD_APPEND));
        send_point(rand_point(CMD_DEST));
        send_point(rand_point(CMD_CLEAR));
    endtask

    // Hold off the sender until every placement is back
    task automatic test_drain_pause();
        send_point(rand_point(CMD_APPEND));
        send_point(rand_point(CMD_DEST));
        wait_drained();
        send_point(rand_point(CMD_DEST));
    endtask

    // Random runs: small source sets, a few destinations each, some noise
    task automatic test_random_frames();
        int sent;
        int nsrc;
        t_cmd_code noise;
        sent = 0;
        while (sent < 190) begin
            if ($urandom_range(0, 9) < 8) send_point(rand_point(CMD_CLEAR));
            nsrc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
            for (int i = 0; i < nsrc; i++) send_point(rand_point(CMD_APPEND));
            for (int i = $urandom_range(1, 3); i > 0; i--) send_point(rand_point(CMD_DEST));
            if ($urandom_range(0, 5) == 0) begin
                noise = t_cmd_code'($urandom_range(0, 3));
                send_point(rand_point(noise));
                sent++;
            end
            sent += nsrc + 2;
        end
    endtask

    // Receiver stall pattern; some stretches with tready held high
    logic ready_steady;
    int   ready_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready   <= 1'b0;
            ready_gap    <= 0;
            ready_steady <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) ready_steady <= ~ready_steady;
            if (ready_steady) begin
                i_m_tready <= 1'b1;
            end else if (ready_gap > 0) begin
                i_m_tready <= 1'b0;
                ready_gap  <= ready_gap - 1;
            end else begin
                i_m_tready <= 1'b1;
                ready_gap  <= gap_len();
            end
        end
    end

    // Compare each placement taken with the oldest one predicted
    always @(posedge i_clk) begin
        t_placed want;
        t_placed got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            {got.attr, got.qw, got.qz, got.qy, got.qx, got.pz, got.py, got.px} = o_m_tdata;
            got.last = o_m_tlast;
            if (placed_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected placement: data %h last %b", o_m_tdata, o_m_tlast);
            end else begin
                want = placed_queue.pop_front();
                if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
                    got.qx !== want.qx || got.qy !== want.qy || got.qz !== want.qz ||
                    got.qw !== want.qw || got.attr !== want.attr ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("placement mismatch");
                        $display("  expected pos %h %h %h rot %h %h %h %h attr %h last %b",
                                 want.px, want.py, want.pz, want.qx, want.qy, want.qz,
                                 want.qw, want.attr, want.last);
                        $display("  actual   pos %h %h %h rot %h %h %h %h attr %h last %b",
                                 got.px, got.py, got.pz, got.qx, got.qy, got.qz,
                                 got.qw, got.attr, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no item taken on either side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            watchdog  <= 0;
            timed_out <= 1'b0;
        end else if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) timed_out <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = CMD_NONE;
        source_count   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_store();
        test_drain_pause();
        test_random_frames();
        wait_drained();
        if (mismatch_count == 0 && placed_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rpaf_pkg.sv
rtl/rpaf_ram.sv
rtl/rpaf_ctrl.sv
rtl/rpaf_dp.sv
rtl/repeat_points_at_frames_core.sv
rtl/rpaf_checker.sv
verif/repeat_points_at_frames_core_test.sv
